// ----- rtl/scpa_pkg.sv -----
// scpa_pkg: shared types and codes for the size class pool allocator
// no dependencies; imported by the allocator modules and the checker
`default_nettype none

package scpa_pkg;

    localparam int SIZE_W = 20;
    localparam int ADDR_W = 25;
    localparam int CLS_W  = 5;
    localparam int OCLS_W = 4;
    localparam int STAT_W = 3;
    localparam int FUNC_W = 2;

    typedef logic [STAT_W-1:0] t_status;
    typedef logic [FUNC_W-1:0] t_func;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_ZERO        = 3'd1;
    localparam t_status ST_OVERSIZE    = 3'd2;
    localparam t_status ST_EXHAUSTED   = 3'd3;
    localparam t_status ST_NOT_GROWING = 3'd4;

    localparam t_func FN_ALLOC   = 2'd0;
    localparam t_func FN_FREE    = 2'd1;
    localparam t_func FN_REALLOC = 2'd2;

    typedef struct packed {
        logic             zero;
        logic             oversize;
        logic [CLS_W-1:0] cls;
    } t_cls_res;

endpackage

`default_nettype wire

// ----- rtl/scpa_ram.sv -----
// scpa_ram: generic single write port, single read port ram
// registered read data; no dependencies
`default_nettype none

module scpa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/scpa_class_unit.sv -----
// scpa_class_unit: shared size to class encoder (round up to power of two)
// depends on scpa_pkg
`default_nettype none

module scpa_class_unit #(
    parameter int MIN_CLASS_LOG2 = 5,
    parameter int CLASS_COUNT    = 11
) (
    input  logic [scpa_pkg::SIZE_W-1:0] i_size,
    output scpa_pkg::t_cls_res          o_res
);
    import scpa_pkg::*;

    logic [SIZE_W-1:0] x;
    logic [CLS_W-1:0]  msb;
    logic [CLS_W-1:0]  cls;

    always_comb begin
        x   = (i_size - SIZE_W'(1)) | SIZE_W'((1 << MIN_CLASS_LOG2) - 1);
        msb = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (x[i]) begin
                msb = CLS_W'(i);
            end
        end
        cls = msb + CLS_W'(1) - CLS_W'(MIN_CLASS_LOG2);
    end

    assign o_res.zero     = (i_size == '0);
    assign o_res.cls      = cls;
    assign o_res.oversize = (cls >= CLS_W'(CLASS_COUNT));

endmodule

`default_nettype wire

// ----- rtl/size_class_pool_allocator_unit.sv -----
// size_class_pool_allocator_unit: an accepted item runs from S_DEC to S_DONE, then the result
// is registered (ignored or rejected items go straight to S_DONE, allocate from never-used
// blocks passes S_TAKE, list pop S_TAKE and S_POP, moving reallocate up to S_OLD, S_TAKE,
// S_POP and S_GIVE); the sequencer walks the single link ram port and the shared class encoder
// with one item in flight plus one held result; S_DONE waits while the output is stalled
// reset: synchronous active low; lists empty and region counters reloaded at once,
// link ram is not cleared (entries are written by a free before they are read)
`default_nettype none

module size_class_pool_allocator_unit #(
    parameter int MIN_CLASS_LOG2 = 5,
    parameter int CLASS_COUNT    = 11,
    parameter int REGION_LOG2    = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  scpa_pkg::t_func             i_func,
    input  logic [scpa_pkg::SIZE_W-1:0] i_request_size,
    input  logic [scpa_pkg::SIZE_W-1:0] i_old_size,
    input  logic [scpa_pkg::ADDR_W-1:0] i_block_address,
    input  logic                        i_address_is_null,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output scpa_pkg::t_status           o_status,
    output logic [scpa_pkg::ADDR_W-1:0] o_result_address,
    output logic [scpa_pkg::OCLS_W-1:0] o_size_class,
    output logic                        o_must_copy
);
    import scpa_pkg::*;

    localparam int SPAN    = REGION_LOG2 - MIN_CLASS_LOG2;
    localparam int IDX_W   = SPAN;
    localparam int LEFT_W  = SPAN + 1;
    localparam int LINK_AW = SPAN + 1;
    localparam int LINK_W  = SPAN + 1;
    localparam int LINK_DEPTH = 1 << LINK_AW;
    localparam int CI_W    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int SH_W    = 6;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_OLD  = 7'b0000100,
        S_TAKE = 7'b0001000,
        S_POP  = 7'b0010000,
        S_GIVE = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // latched item
    t_func             r_func;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_old;
    logic [ADDR_W-1:0] r_addr;
    logic              r_null;

    // working registers
    logic [CLS_W-1:0]  r_cls;
    logic [CLS_W-1:0]  r_gcls;
    logic              r_give_pend;
    logic [IDX_W-1:0]  r_idx;
    t_status           r_status;
    logic [ADDR_W-1:0] r_res_addr;
    logic [OCLS_W-1:0] r_res_cls;
    logic              r_copy;

    // per class state
    logic [IDX_W-1:0]  r_head   [CLASS_COUNT];
    logic              r_head_v [CLASS_COUNT];
    logic [IDX_W-1:0]  r_bump   [CLASS_COUNT];
    logic [LEFT_W-1:0] r_left   [CLASS_COUNT];

    // output register
    logic              r_out_valid;
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_addr;
    logic [OCLS_W-1:0] r_o_cls;
    logic              r_o_copy;

    t_cls_res          cu_res;
    logic [SIZE_W-1:0] cu_size;
    logic [CLS_W-1:0]  cs;
    logic [CI_W-1:0]   si;
    logic [SH_W-1:0]   sh;
    logic              hv;
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  bump;
    logic [LEFT_W-1:0] left;
    logic [IDX_W-1:0]  gidx;
    logic              give_ok;
    logic              in_acc;
    logic              out_free;
    logic              func_ok;
    logic              grow_fail;
    logic              ram_we, ram_re;
    logic [LINK_AW-1:0] ram_waddr, ram_raddr;
    logic [LINK_W-1:0]  ram_wdata, ram_rdata;

    function automatic logic [LINK_AW-1:0] link_slot(input logic [CLS_W-1:0] c,
                                                     input logic [IDX_W-1:0] idx);
        logic [LINK_AW-1:0] base;
        base = ~({LINK_AW{1'b1}} >> c);
        return base + LINK_AW'(idx);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CLS_W-1:0] c,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [SH_W-1:0]  s);
        return (ADDR_W'(c) << REGION_LOG2) | (ADDR_W'(idx) << s);
    endfunction

    scpa_class_unit #(
        .MIN_CLASS_LOG2 (MIN_CLASS_LOG2),
        .CLASS_COUNT    (CLASS_COUNT)
    ) u_cls (
        .i_size (cu_size),
        .o_res  (cu_res)
    );

    scpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cu_size   = (r_state == S_OLD) ? r_old : r_size;
    assign cs        = (r_state == S_GIVE) ? r_gcls : r_cls;
    assign si        = cs[CI_W-1:0];
    assign sh        = SH_W'(MIN_CLASS_LOG2) + SH_W'(cs);
    assign hv        = r_head_v[si];
    assign head      = r_head[si];
    assign bump      = r_bump[si];
    assign left      = r_left[si];
    assign gidx      = IDX_W'(r_addr[REGION_LOG2-1:0] >> sh);
    assign give_ok   = (cs <= CLS_W'(SPAN));
    assign func_ok   = (r_func == FN_ALLOC) || (r_func == FN_FREE) || (r_func == FN_REALLOC);
    assign grow_fail = (r_old != '0) && (r_size <= r_old);

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign ram_re    = (r_state == S_TAKE) && hv;
    assign ram_raddr = link_slot(cs, head);
    assign ram_we    = (r_state == S_GIVE) && give_ok;
    assign ram_waddr = link_slot(cs, gidx);
    assign ram_wdata = hv ? {1'b1, head} : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_DEC;
            end
            S_DEC: begin
                priority if (!func_ok || (r_func == FN_FREE && r_null)) begin
                    n_state = S_DONE;
                end else if (cu_res.zero || cu_res.oversize) begin
                    n_state = S_DONE;
                end else if (r_func == FN_ALLOC) begin
                    n_state = S_TAKE;
                end else if (r_func == FN_FREE) begin
                    n_state = S_GIVE;
                end else if (grow_fail) begin
                    n_state = S_DONE;
                end else if (r_old != '0) begin
                    n_state = S_OLD;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_OLD: begin
                n_state = (cu_res.cls == r_cls) ? S_DONE : S_TAKE;
            end
            S_TAKE: begin
                priority if (hv) begin
                    n_state = S_POP;
                end else if (left == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = r_give_pend ? S_GIVE : S_DONE;
                end
            end
            S_POP: begin
                n_state = r_give_pend ? S_GIVE : S_DONE;
            end
            S_GIVE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
                r_head_v[k] <= 1'b0;
                r_bump[k]   <= '0;
                r_left[k]   <= (k <= SPAN) ? (LEFT_W'(1) << (SPAN - k)) : '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_TAKE && !hv && left != '0) begin
                r_bump[si] <= bump + IDX_W'(1);
                r_left[si] <= left - LEFT_W'(1);
            end
            if (r_state == S_POP) begin
                r_head_v[si] <= ram_rdata[IDX_W];
            end
            if (r_state == S_GIVE && give_ok) begin
                r_head_v[si] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_size <= i_request_size;
            r_old  <= i_old_size;
            r_addr <= i_block_address;
            r_null <= i_address_is_null;
        end
        unique case (r_state)
            S_DEC: begin
                r_copy      <= 1'b0;
                r_give_pend <= 1'b0;
                r_cls       <= cu_res.cls;
                r_gcls      <= cu_res.cls;
                priority if (!func_ok || (r_func == FN_FREE && r_null)) begin
                    r_status   <= ST_OK;
                    r_res_addr <= '0;
                    r_res_cls  <= '0;
                end else if (cu_res.zero) begin
                    r_status   <= ST_ZERO;
                    r_res_addr <= '0;
                    r_res_cls  <= '0;
                end else if (cu_res.oversize) begin
                    r_status   <= ST_OVERSIZE;
                    r_res_addr <= '0;
                    r_res_cls  <= '0;
                end else if (r_func == FN_FREE) begin
                    r_status   <= ST_OK;
                    r_res_addr <= '0;
                    r_res_cls  <= OCLS_W'(cu_res.cls);
                end else if (r_func == FN_REALLOC && grow_fail) begin
                    r_status   <= ST_NOT_GROWING;
                    r_res_addr <= r_addr;
                    r_res_cls  <= '0;
                end else begin
                    r_status   <= ST_OK;
                    r_res_addr <= '0;
                    r_res_cls  <= '0;
                end
            end
            S_OLD: begin
                if (cu_res.cls == r_cls) begin
                    r_res_addr <= r_addr;
                    r_res_cls  <= OCLS_W'(r_cls);
                end else begin
                    r_gcls      <= cu_res.cls;
                    r_give_pend <= !r_null;
                end
            end
            S_TAKE: begin
                priority if (hv) begin
                    r_idx <= head;
                end else if (left == '0) begin
                    r_status <= ST_EXHAUSTED;
                end else begin
                    r_res_addr <= addr_of(cs, bump, sh);
                    r_res_cls  <= OCLS_W'(cs);
                    r_copy     <= r_give_pend;
                end
            end
            S_POP: begin
                r_head[si] <= ram_rdata[IDX_W-1:0];
                r_res_addr <= addr_of(cs, r_idx, sh);
                r_res_cls  <= OCLS_W'(cs);
                r_copy     <= r_give_pend;
            end
            S_GIVE: begin
                if (give_ok) begin
                    r_head[si] <= gidx;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_o_status <= r_status;
                    r_o_addr   <= r_res_addr;
                    r_o_cls    <= r_res_cls;
                    r_o_copy   <= r_copy;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_result_address = r_o_addr;
    assign o_size_class     = r_o_cls;
    assign o_must_copy      = r_o_copy;

endmodule

`default_nettype wire

// ----- rtl/scpa_checker.sv -----
// scpa_checker: port level assertions for size_class_pool_allocator_unit
// depends on scpa_pkg; bound to the top level at the end of this file
`default_nettype none

module scpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input scpa_pkg::t_status           o_status,
    input logic [scpa_pkg::ADDR_W-1:0] o_result_address,
    input logic [scpa_pkg::OCLS_W-1:0] o_size_class,
    input logic                        o_must_copy
);
    import scpa_pkg::*;

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again without a busy cycle");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) &&
            $stable(o_result_address) && $stable(o_size_class) && $stable(o_must_copy)))
        else $error("stalled result changed");

    a_copy_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_must_copy) |-> (o_status == ST_OK && o_size_class != '0))
        else $error("copy flag on a failed or smallest class result");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_ZERO || o_status == ST_OVERSIZE ||
            o_status == ST_EXHAUSTED)) |->
        (o_result_address == '0 && o_size_class == '0 && !o_must_copy))
        else $error("failed result carries address, class or copy flag");

endmodule

bind size_class_pool_allocator_unit scpa_checker u_scpa_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for size_class_pool_allocator_unit, with its own free-list shadow
// depends on scpa_pkg and the allocator rtl; directed items, then random pool traffic

module tb;
    import scpa_pkg::*;

    localparam int MIN_CLASS_LOG2  = 5;
    localparam int CLASS_COUNT     = 11;
    localparam int REGION_LOG2     = 21;
    localparam int CLASS_SLOTS     = 16;
    localparam int SPAN_LOG2       = REGION_LOG2 - MIN_CLASS_LOG2;
    localparam int LINK_BITS       = SPAN_LOG2 + 1;
    localparam int LINK_DEPTH      = 1 << (SPAN_LOG2 + 1);
    localparam int LINK_VALID      = 1 << SPAN_LOG2;
    localparam int MAX_SIZE        = (1 << SIZE_W) - 1;
    localparam int MAX_ADDR        = 23068671;
    localparam int TOP_CLASS_BYTES = 1 << (MIN_CLASS_LOG2 + CLASS_COUNT - 1);
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_ITEMS     = 480;
    localparam int POOL_CAP        = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int QUIET_LIMIT     = 4000;

    localparam t_func FN_UNUSED = 2'd3;

    typedef struct packed {
        t_func             func;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] old;
        logic [ADDR_W-1:0] addr;
        logic              is_null;
    } t_alloc_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [OCLS_W-1:0] cls;
        logic              copy;
    } t_alloc_result;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_live_block;

    class t_alloc_tracker;
        bit [SPAN_LOG2-1:0] list_head [CLASS_SLOTS];
        bit                 list_live [CLASS_SLOTS];
        bit [SPAN_LOG2-1:0] bump_next [CLASS_SLOTS];
        bit [SPAN_LOG2:0]   fresh_left [CLASS_SLOTS];
        bit [SPAN_LOG2:0]   link_of [int];
        t_alloc_result      pending_results [$];
        int                 failures;

        function new();
            for (int c = 0; c < CLASS_SLOTS; c++) begin
                list_head[c]  = '0;
                list_live[c]  = 1'b0;
                bump_next[c]  = '0;
                fresh_left[c] = LINK_BITS'(region_blocks(c));
            end
            failures = 0;
        endfunction

        function int size_class_of(logic [SIZE_W-1:0] size);
            logic [SIZE_W-1:0] x;
            int bits;
            x = (size - 1'b1) | SIZE_W'((1 << MIN_CLASS_LOG2) - 1);
            bits = 0;
            while (x != 0) begin
                bits++;
                x = x >> 1;
            end
            return bits - MIN_CLASS_LOG2;
        endfunction

        function int region_blocks(int c);
            if (c > SPAN_LOG2) return 0;
            return 1 << (SPAN_LOG2 - c);
        endfunction

        function int link_base(int c);
            return LINK_DEPTH - (LINK_DEPTH >> c);
        endfunction

        function logic [ADDR_W-1:0] block_addr(int c, int idx);
            return ADDR_W'((c << REGION_LOG2) | (idx << (MIN_CLASS_LOG2 + c)));
        endfunction

        // list pop first, then a never-used block
        function t_status take_block(int c, output int idx);
            int slot;
            int link;
            idx = 0;
            if (list_live[c]) begin
                slot = link_base(c) + int'(list_head[c]);
                link = (slot < LINK_DEPTH && link_of.exists(slot)) ? int'(link_of[slot]) : 0;
                idx = int'(list_head[c]);
                list_head[c] = SPAN_LOG2'(link & (LINK_VALID - 1));
                list_live[c] = (link & LINK_VALID) != 0;
                return ST_OK;
            end
            if (fresh_left[c] == 0) return ST_EXHAUSTED;
            idx = int'(bump_next[c]);
            bump_next[c]++;
            fresh_left[c]--;
            return ST_OK;
        endfunction

        function void give_block(int c, logic [ADDR_W-1:0] addr);
            int idx;
            int slot;
            if (region_blocks(c) == 0) return;
            idx = (addr & ((1 << REGION_LOG2) - 1)) >> (MIN_CLASS_LOG2 + c);
            if (idx >= region_blocks(c)) return;
            slot = link_base(c) + idx;
            if (slot >= LINK_DEPTH) return;
            link_of[slot] = list_live[c] ? LINK_BITS'(LINK_VALID | int'(list_head[c])) : '0;
            list_head[c] = SPAN_LOG2'(idx);
            list_live[c] = 1'b1;
        endfunction

        function t_alloc_result note_request(t_alloc_req r);
            t_alloc_result res;
            int c;
            int idx;
            res = '0;
            if ((r.func == FN_ALLOC || r.func == FN_FREE || r.func == FN_REALLOC) &&
                !(r.func == FN_FREE && r.is_null)) begin
                c = (r.size == 0) ? 0 : size_class_of(r.size);
                if (r.size == 0) begin
                    res.status = ST_ZERO;
                end else if (c >= CLASS_COUNT) begin
                    res.status = ST_OVERSIZE;
                end else if (r.func == FN_ALLOC) begin
                    res.status = take_block(c, idx);
                    if (res.status == ST_OK) begin
                        res.addr = block_addr(c, idx);
                        res.cls  = OCLS_W'(c);
                    end
                end else if (r.func == FN_FREE) begin
                    give_block(c, r.addr);
                    res.cls = OCLS_W'(c);
                end else if (r.old != 0 && r.size <= r.old) begin
                    res.status = ST_NOT_GROWING;
                    res.addr   = r.addr;
                end else if (r.old != 0 && size_class_of(r.old) == c) begin
                    res.addr = r.addr;
                    res.cls  = OCLS_W'(c);
                end else begin
                    res.status = take_block(c, idx);
                    if (res.status == ST_OK) begin
                        res.addr = block_addr(c, idx);
                        res.cls  = OCLS_W'(c);
                        if (r.old != 0 && !r.is_null) begin
                            give_block(size_class_of(r.old), r.addr);
                            res.copy = 1'b1;
                        end
                    end
                end
            end
            pending_results.push_back(res);
            return res;
        endfunction

        function void check_response(t_alloc_result got);
            t_alloc_result want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d addr %h class %0d copy %0b",
                             got.status, got.addr, got.cls, got.copy);
                end
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.addr !== want.addr ||
                got.cls !== want.cls || got.copy !== want.copy) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("mismatch: expected status %0d addr %h class %0d copy %0b",
                             want.status, want.addr, want.cls, want.copy);
                    $display("          got      status %0d addr %h class %0d copy %0b",
                             got.status, got.addr, got.cls, got.copy);
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_in_valid        = 1'b0;
    logic              o_in_stall;
    t_func             i_func            = FN_ALLOC;
    logic [SIZE_W-1:0] i_request_size    = '0;
    logic [SIZE_W-1:0] i_old_size        = '0;
    logic [ADDR_W-1:0] i_block_address   = '0;
    logic              i_address_is_null = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall       = 1'b0;
    t_status           o_status;
    logic [ADDR_W-1:0] o_result_address;
    logic [OCLS_W-1:0] o_size_class;
    logic              o_must_copy;

    t_alloc_tracker tracker;
    t_live_block    live_blocks [$];
    int             idle_pct  = 0;
    int             stall_pct = 0;
    int             quiet_cycles = 0;

    size_class_pool_allocator_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_request_size    (i_request_size),
        .i_old_size        (i_old_size),
        .i_block_address   (i_block_address),
        .i_address_is_null (i_address_is_null),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_result_address  (o_result_address),
        .o_size_class      (o_size_class),
        .o_must_copy       (o_must_copy)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_response(t_alloc_result'({o_status, o_result_address,
                                                    o_size_class, o_must_copy}));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(input t_alloc_req r, output t_alloc_result predicted);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func            <= r.func;
        i_request_size    <= r.size;
        i_old_size        <= r.old;
        i_block_address   <= r.addr;
        i_address_is_null <= r.is_null;
        i_in_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = tracker.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic direct(t_func f, int size, int old, int addr, bit is_null);
        t_alloc_result unused_res;
        send_request(t_alloc_req'({f, SIZE_W'(size), SIZE_W'(old), ADDR_W'(addr), is_null}),
                     unused_res);
    endtask

    function automatic logic [SIZE_W-1:0] size_for_class(int c);
        if (c == 0) return SIZE_W'($urandom_range(1, 1 << MIN_CLASS_LOG2));
        return SIZE_W'($urandom_range((1 << (c + MIN_CLASS_LOG2 - 1)) + 1,
                                      1 << (c + MIN_CLASS_LOG2)));
    endfunction

    // the two largest classes run out first, so weight them
    function automatic int pick_class();
        if ($urandom_range(0, 99) < 40) return $urandom_range(CLASS_COUNT - 2, CLASS_COUNT - 1);
        return $urandom_range(0, CLASS_COUNT - 1);
    endfunction

    function automatic t_alloc_req scrambled_request();
        t_alloc_req r;
        r.func    = t_func'($urandom_range(0, 2));
        r.size    = SIZE_W'($urandom_range(0, MAX_SIZE));
        r.old     = SIZE_W'($urandom_range(0, MAX_SIZE));
        r.addr    = ADDR_W'($urandom_range(0, MAX_ADDR));
        r.is_null = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic fill_top_class();
        t_alloc_req    r;
        t_alloc_result got;
        int            misses;
        t_live_block   small_blk;
        r = scrambled_request();
        r.func = FN_ALLOC;
        r.size = size_for_class(2);
        send_request(r, got);
        small_blk = '{got.addr, r.size};
        misses = 0;
        while (misses < 3) begin
            r = scrambled_request();
            r.func = FN_ALLOC;
            r.size = size_for_class(CLASS_COUNT - 1);
            send_request(r, got);
            if (got.status == ST_EXHAUSTED) begin
                misses++;
            end else begin
                live_blocks.push_back('{got.addr, r.size});
            end
        end
        // moving into a full class must keep the old block
        r = scrambled_request();
        r.func    = FN_REALLOC;
        r.size    = size_for_class(CLASS_COUNT - 1);
        r.old     = small_blk.size;
        r.addr    = small_blk.addr;
        r.is_null = 1'b0;
        send_request(r, got);
        live_blocks.push_back(got.status == ST_OK ? t_live_block'({got.addr, r.size})
                                                   : small_blk);
    endtask

    task automatic random_request();
        t_alloc_req    r;
        t_alloc_result got;
        t_live_block   blk;
        int            pick;
        int            k;
        int            c;
        int            pos;
        int            top;
        bit            keep;
        bit            resize;
        r      = scrambled_request();
        keep   = 1'b0;
        resize = 1'b0;
        pos    = 0;
        pick   = $urandom_range(0, 99);
        if (live_blocks.size() > POOL_CAP) pick = 50;
        if (live_blocks.size() == 0 && pick >= 42 && pick < 88) pick = 0;
        if (pick < 42) begin
            r.func = FN_ALLOC;
            r.size = size_for_class(pick_class());
            keep   = 1'b1;
        end else if (pick < 64) begin
            pos = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[pos];
            live_blocks.delete(pos);
            r.func    = FN_FREE;
            r.addr    = blk.addr;
            r.is_null = 1'b0;
            r.size    = ($urandom_range(0, 3) == 0) ?
                        size_for_class(tracker.size_class_of(blk.size)) : blk.size;
        end else if (pick < 88) begin
            pos = $urandom_range(0, live_blocks.size() - 1);
            blk = live_blocks[pos];
            r.func    = FN_REALLOC;
            r.old     = blk.size;
            r.addr    = blk.addr;
            r.is_null = 1'b0;
            resize    = 1'b1;
            k = $urandom_range(0, 9);
            if (k < 2) begin
                r.size = SIZE_W'($urandom_range(1, blk.size));
            end else if (k < 4) begin
                c   = tracker.size_class_of(blk.size);
                top = 1 << (c + MIN_CLASS_LOG2);
                r.size = (blk.size < top) ? SIZE_W'($urandom_range(blk.size + 1, top))
                                          : blk.size + 1'b1;
            end else begin
                r.size = size_for_class(pick_class());
            end
        end else begin
            case ($urandom_range(0, 9))
                0: r.size = '0;
                1: r.size = SIZE_W'($urandom_range(TOP_CLASS_BYTES + 1, MAX_SIZE));
                2: begin
                    r.func    = FN_FREE;
                    r.is_null = 1'b1;
                end
                3: begin
                    r.func    = FN_FREE;
                    r.is_null = 1'b0;
                    r.size    = size_for_class(pick_class());
                end
                4: begin
                    r.func    = FN_FREE;
                    r.is_null = 1'b0;
                    if (live_blocks.size() != 0) begin
                        blk    = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        r.addr = blk.addr;
                        r.size = blk.size;
                    end else begin
                        r.size = size_for_class(pick_class());
                    end
                end
                5: begin
                    r.func = FN_REALLOC;
                    r.old  = '0;
                    r.size = size_for_class(pick_class());
                    keep   = 1'b1;
                end
                6: begin
                    r.func    = FN_REALLOC;
                    r.is_null = 1'b1;
                    r.old     = SIZE_W'($urandom_range(1, TOP_CLASS_BYTES));
                    r.size    = size_for_class(pick_class());
                    keep      = 1'b1;
                end
                7: r.func = FN_UNUSED;
                8: r.func = FN_REALLOC;
                default: ;
            endcase
        end
        send_request(r, got);
        if (got.status == ST_OK && keep) live_blocks.push_back('{got.addr, r.size});
        if (got.status == ST_OK && resize) live_blocks[pos] = '{got.addr, r.size};
    endtask

    initial begin
        tracker = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        direct(FN_ALLOC, 1, 0, 0, 0);
        direct(FN_ALLOC, 32, 0, 0, 0);
        direct(FN_ALLOC, 33, MAX_SIZE, MAX_ADDR, 1);
        direct(FN_ALLOC, TOP_CLASS_BYTES, 0, 0, 0);
        direct(FN_ALLOC, 0, 7, 96, 0);
        direct(FN_ALLOC, TOP_CLASS_BYTES + 1, 0, 0, 0);
        direct(FN_ALLOC, MAX_SIZE, MAX_SIZE, MAX_ADDR, 1);
        direct(FN_FREE, 32, 0, 0, 0);
        direct(FN_ALLOC, 20, 0, 0, 0);
        direct(FN_FREE, 5, 0, MAX_ADDR, 1);
        direct(FN_FREE, 0, 0, 32, 0);
        direct(FN_REALLOC, 64, 32, 32, 0);
        direct(FN_REALLOC, 16, 40, MAX_ADDR, 0);
        direct(FN_REALLOC, 40, 40, 64, 0);
        direct(FN_REALLOC, 60, 40, (1 << REGION_LOG2) | 64, 0);
        direct(FN_REALLOC, 100, 0, 0, 1);
        direct(FN_REALLOC, 200, 50, 0, 1);
        direct(FN_REALLOC, 40000, 100, 64, 0);
        direct(FN_REALLOC, MAX_SIZE, MAX_SIZE, MAX_ADDR, 0);
        direct(FN_REALLOC, 0, 10, 64, 0);
        // class bits and offset bits below the block are ignored
        direct(FN_FREE, 64, 0, (7 << REGION_LOG2) | 69, 0);
        direct(FN_FREE, 64, 0, (7 << REGION_LOG2) | 69, 0);
        direct(FN_ALLOC, 64, 0, 0, 0);
        direct(FN_UNUSED, MAX_SIZE, MAX_SIZE, MAX_ADDR, 1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            if (phase == 0) fill_top_class();
            repeat (PHASE_ITEMS) random_request();
        end

        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
